>>> hw/rtl/dpk_pkg.sv
// Shared types and constants of the 3x3 elevation peak extractor.
package dpk_pkg;

  localparam int COL_OUT_W  = 12;
  localparam int ROW_W      = 16;
  localparam int WIDTH_W    = 13;
  localparam int NODATA_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Depth of the result queue and the width of its pointers and fill count.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd4096;
  localparam logic [ROW_W-1:0]    HEIGHT_RESET = 16'd4096;
  localparam logic [NODATA_W-1:0] NODATA_RESET = 32'h8000_0000;
  localparam logic [ROW_W:0]      MIN_DIM      = 17'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_NODATA_VALUE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
  } peak_entry_t;

endpackage

>>> hw/rtl/dpk_sample_if.sv
// Valid/ready channel that carries one elevation sample per beat.
interface dpk_sample_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] elevation;

  modport source (output valid, output elevation, input ready);
  modport sink   (input valid, input elevation, output ready);
endinterface

>>> hw/rtl/dpk_peak_if.sv
// Valid/ready channel that carries the position of one detected peak per beat.
interface dpk_peak_if;
  logic                               valid;
  logic                               ready;
  logic [dpk_pkg::COL_OUT_W-1:0]      peak_col;
  logic [dpk_pkg::ROW_W-1:0]          peak_row;

  modport source (output valid, output peak_col, output peak_row, input ready);
  modport sink   (input valid, input peak_col, input peak_row, output ready);
endinterface

>>> hw/rtl/dpk_cfg_if.sv
// Register write channel: one register index and its data per beat.
interface dpk_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dpk_pkg::CFG_IDX_W-1:0]    index;
  logic [dpk_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/dpk_line_buffer.sv
// Two line memories holding the two previous raster rows.
module dpk_line_buffer #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_top,
  output logic [DATA_W-1:0] rd_mid,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_pix
);

  logic [DATA_W-1:0] upper_mem  [DEPTH];
  logic [DATA_W-1:0] middle_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_top <= upper_mem[rd_addr];
      rd_mid <= middle_mem[rd_addr];
    end
  end

  // The middle sample read for this column moves up one row when the new one lands.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= rd_mid;
      middle_mem[wr_addr] <= wr_pix;
    end
  end

endmodule

>>> hw/rtl/dpk_window_cell.sv
// One column of the 3x3 window; it takes its neighbor's column on every shift.
module dpk_window_cell #(
  parameter int DATA_W = 32
) (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic [2:0][DATA_W-1:0] col_in,
  output logic [2:0][DATA_W-1:0] col_out
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_out <= col_in;
    end
  end

endmodule

>>> hw/rtl/dem_peak_3x3_extract_unit.sv
// Top level of the streaming 3x3 elevation peak extractor.
// The block takes one elevation sample per clock in raster order and, once the
// first two rows and columns of a frame are in, checks the pixel one row up and
// one column left of the newest sample: it is reported by column and row when
// all eight neighbors are strictly lower and none equals the nodata code. Border
// pixels are never reported. A result passes the stage 1 and window registers and
// is offered on the peak channel from the result queue. The sustained rate is one
// sample per cycle, set by the single read and single write port of each line
// memory that every sample uses once, as long as the peak receiver keeps up;
// when four results are queued or in flight the sample input stalls until the
// receiver takes one.
// The line memories need no clearing pass, so the block is ready right after reset.
// The user must write configuration only while no sample is in flight; the block
// itself does not enforce this. A new width or height takes effect at once.
module dem_peak_3x3_extract_unit #(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  dpk_sample_if.sink    pixel,
  dpk_peak_if.source    peak,
  dpk_cfg_if.sink       cfg
);

  // Column counter width and a compare width wide enough for any width setting.
  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = ($clog2(MAX_WIDTH + 1) > dpk_pkg::WIDTH_W) ?
                      $clog2(MAX_WIDTH + 1) + 1 : dpk_pkg::WIDTH_W + 1;
  localparam logic [EW-1:0] MAX_W_EXT = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MIN_W_EXT = EW'(3);

  // ---------------------------------------------------------------------------
  // Configuration registers. The write channel never stalls.
  // ---------------------------------------------------------------------------
  logic [dpk_pkg::WIDTH_W-1:0]  image_width;
  logic [dpk_pkg::ROW_W-1:0]    image_height;
  logic [dpk_pkg::NODATA_W-1:0] nodata_value;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= dpk_pkg::WIDTH_RESET;
      image_height <= dpk_pkg::HEIGHT_RESET;
      nodata_value <= dpk_pkg::NODATA_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        dpk_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg.data[dpk_pkg::WIDTH_W-1:0];
        dpk_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg.data[dpk_pkg::ROW_W-1:0];
        dpk_pkg::CFG_NODATA_VALUE: nodata_value <= cfg.data;
        default: ;
      endcase
    end
  end

  // Effective frame size: width clamped to [3, MAX_WIDTH], height at least 3.
  logic [EW-1:0]            width_ext;
  logic [EW-1:0]            eff_width;
  logic [dpk_pkg::ROW_W:0]  eff_height;

  always_comb begin
    width_ext = EW'(image_width);
    if (width_ext < MIN_W_EXT) begin
      eff_width = MIN_W_EXT;
    end else if (width_ext > MAX_W_EXT) begin
      eff_width = MAX_W_EXT;
    end else begin
      eff_width = width_ext;
    end
    eff_height = {1'b0, image_height};
    if (eff_height < dpk_pkg::MIN_DIM) begin
      eff_height = dpk_pkg::MIN_DIM;
    end
  end

  // ---------------------------------------------------------------------------
  // Input acceptance and raster position.
  // The pipeline never stalls; a sample is taken only when the result queue has
  // room for it and for every sample still in the two stages ahead of it.
  // ---------------------------------------------------------------------------
  logic                          s1_valid;
  logic                          s2_valid;
  logic [dpk_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic [dpk_pkg::FIFO_CNT_W-1:0] committed;
  logic                          accept;

  assign committed = fifo_count + dpk_pkg::FIFO_CNT_W'(s1_valid)
                   + dpk_pkg::FIFO_CNT_W'(s2_valid);
  assign pixel.ready = (committed < dpk_pkg::FIFO_CNT_W'(dpk_pkg::FIFO_DEPTH));
  assign accept = pixel.valid && pixel.ready;

  logic [CW-1:0]            col_count;
  logic [dpk_pkg::ROW_W-1:0] row_count;
  logic                      last_col;
  logic                      last_row;

  assign last_col = ((EW'(col_count) + EW'(1)) >= eff_width);
  assign last_row = (({1'b0, row_count} + 17'd1) >= eff_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + 16'd1;
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the sample is registered here while the line memories return the
  // two samples above it in the same column.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0]    s1_pix;
  logic [CW-1:0]             s1_col;
  logic [dpk_pkg::ROW_W-1:0] s1_row;
  logic                      s1_test;
  logic [SAMPLE_BITS-1:0]    mem_top;
  logic [SAMPLE_BITS-1:0]    mem_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= pixel.elevation;
      s1_col  <= col_count;
      s1_row  <= row_count;
      s1_test <= (col_count >= CW'(2)) && (row_count >= 16'd2);
    end
  end

  dpk_line_buffer #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (SAMPLE_BITS),
    .ADDR_W (CW)
  ) u_line_buffer (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_top  (mem_top),
    .rd_mid  (mem_mid),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_pix  (s1_pix)
  );

  // ---------------------------------------------------------------------------
  // Window: a chain of three column cells. The newest column enters cell 2 and
  // each beat moves every column one cell to the left.
  // ---------------------------------------------------------------------------
  logic [2:0][SAMPLE_BITS-1:0] win_col [3];
  logic [2:0][SAMPLE_BITS-1:0] new_col;

  assign new_col = {s1_pix, mem_mid, mem_top};

  for (genvar g = 0; g < 3; g++) begin : g_cell
    dpk_window_cell #(
      .DATA_W (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .shift_en (s1_valid),
      .col_in   ((g == 2) ? new_col : win_col[(g == 2) ? 2 : g + 1]),
      .col_out  (win_col[g])
    );
  end

  // Stage 2 bookkeeping is registered on the same shift as the window.
  logic [CW-1:0]             s2_col;
  logic [dpk_pkg::ROW_W-1:0] s2_row;
  logic                      s2_test;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_col  <= s1_col;
      s2_row  <= s1_row;
      s2_test <= s1_test;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: eight neighbor checks against the window centre. A neighbor that
  // holds the nodata code vetoes the peak, just as an equal height would.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS+dpk_pkg::NODATA_W-1:0] nodata_wide;
  logic [SAMPLE_BITS-1:0]                   nodata_cmp;
  logic signed [SAMPLE_BITS-1:0]            centre;
  logic [7:0]                               lower;
  logic                                     is_peak;

  assign nodata_wide = {{SAMPLE_BITS{1'b0}}, nodata_value};
  assign nodata_cmp  = nodata_wide[SAMPLE_BITS-1:0];
  assign centre      = $signed(win_col[1][1]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lower[k] = ($signed(win_col[0][k]) < centre) && (win_col[0][k] != nodata_cmp);
      lower[k+3] = ($signed(win_col[2][k]) < centre) && (win_col[2][k] != nodata_cmp);
    end
    lower[6] = ($signed(win_col[1][0]) < centre) && (win_col[1][0] != nodata_cmp);
    lower[7] = ($signed(win_col[1][2]) < centre) && (win_col[1][2] != nodata_cmp);
    is_peak  = &lower;
  end

  // The peak sits one column left of and one row above the newest sample.
  logic [CW-1:0]                       col_m1;
  logic [CW+dpk_pkg::COL_OUT_W-1:0]    col_m1_wide;
  dpk_pkg::peak_entry_t                push_entry;
  logic                                push;
  logic                                pop;

  assign col_m1      = s2_col - CW'(1);
  assign col_m1_wide = {{dpk_pkg::COL_OUT_W{1'b0}}, col_m1};
  assign push_entry.col = col_m1_wide[dpk_pkg::COL_OUT_W-1:0];
  assign push_entry.row = s2_row - 16'd1;
  assign push = s2_valid && s2_test && is_peak;

  // ---------------------------------------------------------------------------
  // Result queue. It parts the output handshake from the pipeline, so samples
  // keep flowing while a reported peak waits to be taken.
  // ---------------------------------------------------------------------------
  dpk_pkg::peak_entry_t               fifo_mem [dpk_pkg::FIFO_DEPTH];
  logic [dpk_pkg::FIFO_PTR_W-1:0]     wr_ptr;
  logic [dpk_pkg::FIFO_PTR_W-1:0]     rd_ptr;

  assign peak.valid    = (fifo_count != '0);
  assign peak.peak_col = fifo_mem[rd_ptr].col;
  assign peak.peak_row = fifo_mem[rd_ptr].row;
  assign pop = peak.valid && peak.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + dpk_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + dpk_pkg::FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        fifo_count <= fifo_count + dpk_pkg::FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        fifo_count <= fifo_count - dpk_pkg::FIFO_CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // Samples in flight plus queued results never exceed the queue depth.
  a_credit: assert property (@(posedge clk) disable iff (rst)
    committed <= dpk_pkg::FIFO_CNT_W'(dpk_pkg::FIFO_DEPTH))
    else $error("more samples in flight than result queue entries");

  // A peak is never pushed into a full queue that is not draining.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (fifo_count < dpk_pkg::FIFO_CNT_W'(dpk_pkg::FIFO_DEPTH)))
    else $error("result queue overflow");

  // The column counter stays inside the effective row width.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> (EW'(col_count) < eff_width))
    else $error("column counter left the row");

  // Pixels in the first row or first column are never reported.
  a_interior: assert property (@(posedge clk) disable iff (rst)
    peak.valid |-> (peak.peak_col != '0) && (peak.peak_row != '0))
    else $error("border pixel reported as a peak");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the streaming 3x3 elevation peak extractor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W          = 4096;
  localparam int SMP_W          = 32;
  localparam int RANDOM_ITEMS   = 1500;
  // Extra wait after the last owed peak, for the pipeline and the result queue to empty.
  localparam int DRAIN_CYCLES   = 8;
  // The longest quiet stretch in a correct run is the long receiver hold-off
  // below, plus the pipeline delay and one maximum gap on each side.
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  typedef enum int {
    STYLE_MIXED,
    STYLE_DENSE
  } sample_style_t;

  // One directed frame: the configuration it runs under, its nine samples in
  // raster order, and whether its single interior pixel must be reported.
  typedef struct packed {
    logic [dpk_pkg::WIDTH_W-1:0]  width;
    logic [dpk_pkg::ROW_W-1:0]    height;
    logic [dpk_pkg::NODATA_W-1:0] nodata;
    logic [0:8][SMP_W-1:0]        px;
    logic                         is_peak;
  } frame_vec_t;

  // All three directed frames are 3x3, so their only candidate is (1, 1).
  localparam dpk_pkg::peak_entry_t CENTRE_OF_3X3 = '{col: 12'd1, row: 16'd1};

  localparam frame_vec_t DIRECTED_FRAMES [3] = '{
    // Width and height below the minimum both act as 3. The centre equals the
    // nodata code and is still a peak, because only neighbors are checked against it.
    // The all-ones neighbor is lower as a signed value, higher as an unsigned one.
    '{width: 13'd0, height: 16'd1, nodata: 32'h7FFF_FFFF,
      px: '{32'h8000_0000, 32'h7FFF_FFFE, 32'h0000_0000,
            32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001,
            32'h8000_0001, 32'h1234_5678, 32'h7FFF_FFFE},
      is_peak: 1'b1},
    // A neighbor equal to the nodata code vetoes the peak even though it is
    // the lowest value in the window.
    '{width: 13'd2, height: 16'd2, nodata: 32'h8000_0000,
      px: '{32'h8000_0000, 32'hFFFF_FF00, 32'hFFFF_FF00,
            32'hFFFF_FF00, 32'h0000_0000, 32'hFFFF_FF00,
            32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFFFF_FF00},
      is_peak: 1'b0},
    // A neighbor that ties with the centre is not strictly lower.
    '{width: 13'd3, height: 16'd0, nodata: 32'h0000_0000,
      px: '{32'h0000_0063, 32'h0000_0063, 32'h0000_0063,
            32'h0000_0063, 32'h0000_0064, 32'h0000_0064,
            32'h0000_0063, 32'h0000_0063, 32'h0000_0063},
      is_peak: 1'b0}
  };

  logic clk = 1'b0;
  logic rst;

  dpk_sample_if #(.SAMPLE_BITS(SMP_W)) pixel_bus ();
  dpk_peak_if                          peak_bus ();
  dpk_cfg_if                           cfg_bus ();

  dem_peak_3x3_extract_unit #(
    .MAX_WIDTH   (MAX_W),
    .SAMPLE_BITS (SMP_W)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_bus),
    .peak  (peak_bus),
    .cfg   (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: the two line stores, the 3x3 window, the raster
  // position of the next sample and the register values it works under.
  logic signed [SMP_W-1:0]      upper_row [MAX_W];
  logic signed [SMP_W-1:0]      middle_row [MAX_W];
  logic signed [SMP_W-1:0]      win [9];
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  logic [dpk_pkg::WIDTH_W-1:0]  cfg_width;
  logic [dpk_pkg::ROW_W-1:0]    cfg_height;
  logic signed [SMP_W-1:0]      cfg_nodata;

  // Peak positions that the block still owes us, oldest first.
  dpk_pkg::peak_entry_t pending_peaks [$];

  int  fail_count;
  int  stimulus_count;
  int  quiet_cycles;
  bit  burst_mode;
  bit  hold_off_req;

  // Counts a failure and prints it, as long as the report budget allows.
  function automatic void log_mismatch(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("MISMATCH: %s", msg);
    end
  endfunction

  // Appends one owed peak at the tail of the queue.
  function automatic void owe_peak(input dpk_pkg::peak_entry_t entry);
    pending_peaks.insert(pending_peaks.size(), entry);
  endfunction

  // Idle cycles before the next beat on either side. Burst phases never idle.
  function automatic int draw_gap();
    return burst_mode ? 0 : int'($urandom_range(0, 13));
  endfunction

  // Shifts one sample into the shadow window and returns whether the pixel one
  // row up and one column left is a local maximum, with its position in hit.
  function automatic bit step_window(input logic signed [SMP_W-1:0] elev,
                                     output dpk_pkg::peak_entry_t hit);
    int unsigned w;
    int unsigned h;
    int unsigned slot;
    int j;
    logic signed [SMP_W-1:0] above;
    logic signed [SMP_W-1:0] beside;
    bit is_peak;
    w = (cfg_width < 3) ? 3 : ((cfg_width > MAX_W) ? MAX_W : int'(cfg_width));
    h = (cfg_height < 3) ? 3 : int'(cfg_height);
    slot = col_pos % MAX_W;
    above = upper_row[slot];
    beside = middle_row[slot];
    upper_row[slot] = beside;
    middle_row[slot] = elev;
    for (j = 0; j < 3; j++) begin
      win[3*j]   = win[3*j+1];
      win[3*j+1] = win[3*j+2];
    end
    win[2] = above;
    win[5] = beside;
    win[8] = elev;
    // A nodata neighbor counts as equal to the centre, so it vetoes as a tie.
    is_peak = (col_pos >= 2) && (row_pos >= 2);
    for (j = 0; j < 9; j++) begin
      if (j != 4 && (win[j] == cfg_nodata || win[j] >= win[4])) begin
        is_peak = 1'b0;
      end
    end
    hit.col = dpk_pkg::COL_OUT_W'(col_pos - 1);
    hit.row = dpk_pkg::ROW_W'(row_pos - 1);
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return is_peak;
  endfunction

  // Picks the next sample. The mixed style leans on small values so that ties
  // and nodata hits are common, with full-range values and both extremes mixed
  // in. The dense style raises every odd/odd pixel so that peaks come often.
  function automatic logic [SMP_W-1:0] draw_elevation(input sample_style_t style);
    int unsigned pick;
    logic [SMP_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (style == STYLE_DENSE && pick >= 5) begin
      if (col_pos[0] && row_pos[0]) begin
        v = 32'd100000 + $urandom_range(0, 1000);
      end else begin
        v = 32'd0 - $urandom_range(0, 99999);
      end
    end else if (pick < 35) begin
      v = $urandom_range(0, 15);
    end else if (pick < 65) begin
      v = $urandom();
    end else if (pick < 75) begin
      v = cfg_nodata;
    end else if (pick < 80) begin
      v = 32'h7FFF_FFFF;
    end else if (pick < 85) begin
      v = 32'h8000_0000;
    end else begin
      v = 32'($urandom_range(0, 511)) - 32'd256;
    end
    return v;
  endfunction

  // Offers one sample after a random gap and waits for its beat. At the beat
  // the shadow is advanced; the expected peak is queued unless the caller
  // supplies its own expectation.
  task automatic send_sample(input logic [SMP_W-1:0] elev, input bit use_shadow);
    int gap;
    bit found;
    dpk_pkg::peak_entry_t hit;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      pixel_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_bus.valid <= 1'b1;
    pixel_bus.elevation <= elev;
    do @(posedge clk); while (!pixel_bus.ready);
    found = step_window(elev, hit);
    if (use_shadow && found) begin
      owe_peak(hit);
    end
  endtask

  // Stops the sample stream and lets every owed peak and the pipeline drain,
  // so that the registers can be written safely.
  task automatic wait_idle();
    @(negedge clk);
    pixel_bus.valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input dpk_pkg::cfg_reg_t which,
                           input logic [dpk_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= which;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (which)
      dpk_pkg::CFG_IMAGE_WIDTH:  cfg_width = value[dpk_pkg::WIDTH_W-1:0];
      dpk_pkg::CFG_IMAGE_HEIGHT: cfg_height = value[dpk_pkg::ROW_W-1:0];
      dpk_pkg::CFG_NODATA_VALUE: cfg_nodata = value[dpk_pkg::NODATA_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // One stretch of random stimulus under one register setting. It sends at
  // least min_items samples and, when asked, carries on to the end of the
  // frame so that the next phase may change the width safely.
  task automatic run_phase(input logic [dpk_pkg::WIDTH_W-1:0] width,
                           input logic [dpk_pkg::ROW_W-1:0] height,
                           input logic [dpk_pkg::NODATA_W-1:0] nodata,
                           input int min_items,
                           input bit to_frame_start,
                           input sample_style_t style,
                           input bit hold);
    int sent;
    wait_idle();
    write_reg(dpk_pkg::CFG_IMAGE_WIDTH, dpk_pkg::CFG_DATA_W'(width));
    write_reg(dpk_pkg::CFG_IMAGE_HEIGHT, dpk_pkg::CFG_DATA_W'(height));
    write_reg(dpk_pkg::CFG_NODATA_VALUE, dpk_pkg::CFG_DATA_W'(nodata));
    if (hold) begin
      hold_off_req = 1'b1;
    end
    sent = 0;
    while (sent < min_items || (to_frame_start && (col_pos != 0 || row_pos != 0))) begin
      send_sample(draw_elevation(style), 1'b1);
      sent++;
    end
    stimulus_count += sent;
  endtask

  // Stimulus: directed frames, then the back-pressure and tall-frame phases,
  // then random frames, and finally a short stretch at the widest setting.
  initial begin : stimulus
    int f;
    int k;
    int pick;
    logic [dpk_pkg::WIDTH_W-1:0]  width;
    logic [dpk_pkg::ROW_W-1:0]    height;
    logic [dpk_pkg::NODATA_W-1:0] nodata;
    sample_style_t                style;

    rst = 1'b1;
    pixel_bus.valid = 1'b0;
    pixel_bus.elevation = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = dpk_pkg::CFG_IMAGE_WIDTH;
    cfg_bus.data = '0;
    fail_count = 0;
    stimulus_count = 0;
    burst_mode = 1'b0;
    hold_off_req = 1'b0;

    // Entries that were never written are modelled as zero; no output can
    // depend on them because the width only changes at a frame boundary.
    foreach (upper_row[i]) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    foreach (win[i]) begin
      win[i] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    cfg_width = dpk_pkg::WIDTH_RESET;
    cfg_height = dpk_pkg::HEIGHT_RESET;
    cfg_nodata = dpk_pkg::NODATA_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames carry their expected result in the table. The shadow
    // still follows every sample so that it stays in step with the block.
    for (f = 0; f < 3; f++) begin
      wait_idle();
      write_reg(dpk_pkg::CFG_IMAGE_WIDTH, dpk_pkg::CFG_DATA_W'(DIRECTED_FRAMES[f].width));
      write_reg(dpk_pkg::CFG_IMAGE_HEIGHT, dpk_pkg::CFG_DATA_W'(DIRECTED_FRAMES[f].height));
      write_reg(dpk_pkg::CFG_NODATA_VALUE, dpk_pkg::CFG_DATA_W'(DIRECTED_FRAMES[f].nodata));
      for (k = 0; k < 9; k++) begin
        send_sample(DIRECTED_FRAMES[f].px[k], 1'b0);
      end
      if (DIRECTED_FRAMES[f].is_peak) begin
        owe_peak(CENTRE_OF_3X3);
      end
    end

    // Back-pressure: peak-rich frames streamed without gaps while the peak
    // receiver holds off for a long stretch, so the result queue fills and the
    // block has to stall its sample input.
    burst_mode = 1'b1;
    run_phase(13'd8, 16'd8, $urandom(), 3 * 64, 1'b1, STYLE_DENSE, 1'b1);
    burst_mode = 1'b0;

    // Tallest frame: a few rows at the maximum height, then the height is cut
    // mid-frame, which ends the frame after the row in progress.
    run_phase(13'd5, 16'd65535, $urandom(), 40, 1'b0, STYLE_MIXED, 1'b0);
    run_phase(13'd5, 16'd3, 32'h8000_0000, 1, 1'b1, STYLE_MIXED, 1'b0);

    // Random frames, mostly small, one frame per setting.
    while (stimulus_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        width = dpk_pkg::WIDTH_W'($urandom_range(0, 2));
      end else if (pick == 1) begin
        width = dpk_pkg::WIDTH_W'($urandom_range(17, 64));
      end else begin
        width = dpk_pkg::WIDTH_W'($urandom_range(3, 16));
      end
      height = ($urandom_range(0, 4) == 0) ? dpk_pkg::ROW_W'($urandom_range(0, 2))
                                           : dpk_pkg::ROW_W'($urandom_range(3, 8));
      case ($urandom_range(0, 3))
        0:       nodata = 32'h8000_0000;
        1:       nodata = 32'h7FFF_FFFF;
        2:       nodata = $urandom();
        default: nodata = $urandom_range(0, 15);
      endcase
      style = ($urandom_range(0, 3) == 0) ? STYLE_DENSE : STYLE_MIXED;
      burst_mode = ($urandom_range(0, 4) == 0);
      run_phase(width, height, nodata, 1, 1'b1, style, 1'b0);
    end
    burst_mode = 1'b0;

    // Widest setting: a width above the line store acts as the full store. Only
    // the start of the first row is sent, which keeps the run short.
    run_phase(13'd8191, 16'd3, $urandom(), 64, 1'b0, STYLE_MIXED, 1'b0);

    wait_idle();
    if (fail_count == 0) begin
      $display("dem_peak_3x3_extract_unit test passed");
    end else begin
      $display("dem_peak_3x3_extract_unit test failed");
    end
    $finish;
  end

  // Peak receiver and checker. Every accepted peak is compared with the oldest
  // owed one; after each beat a random stall is drawn, and a hold-off request
  // from the stimulus side turns into one long stall counted here.
  initial begin : peak_sink
    int stall;
    dpk_pkg::peak_entry_t got;
    dpk_pkg::peak_entry_t want;
    stall = 0;
    peak_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && peak_bus.valid && peak_bus.ready) begin
        got.col = peak_bus.peak_col;
        got.row = peak_bus.peak_row;
        if (pending_peaks.size() == 0) begin
          log_mismatch($sformatf("expected no peak, got col %0d row %0d",
                                 got.col, got.row));
        end else begin
          want = pending_peaks.pop_front();
          if (got.col !== want.col || got.row !== want.row) begin
            log_mismatch($sformatf("expected peak col %0d row %0d, got col %0d row %0d",
                                   want.col, want.row, got.col, got.row));
          end
        end
        stall = draw_gap();
      end
      @(negedge clk);
      if (hold_off_req) begin
        stall = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        peak_bus.ready <= 1'b0;
        stall--;
      end else begin
        peak_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any beat on any channel proves progress. A long run of cycles
  // without one means the block hung or a peak it owes never came.
  always @(posedge clk) begin
    if (rst || (pixel_bus.valid && pixel_bus.ready) || (peak_bus.valid && peak_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("dem_peak_3x3_extract_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
